// ===== design/dbs_pkg.sv =====
package dbs_pkg;

    localparam int CB = 16;
    localparam int W  = CB + 4;
    localparam int FIELD_BITS = 16;

    localparam logic [1:0] OP_FRAME   = 2'd0;
    localparam logic [1:0] OP_PRESS   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_MOTION  = 2'd3;

    localparam logic [2:0] REG_WINDOW_WIDTH    = 3'd0;
    localparam logic [2:0] REG_WINDOW_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_SPRITE_WIDTH    = 3'd2;
    localparam logic [2:0] REG_SPRITE_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_GRAVITY_STEP    = 3'd4;
    localparam logic [2:0] REG_WALL_LOSS       = 3'd5;
    localparam logic [2:0] REG_FRICTION_PERIOD = 3'd6;

    localparam logic [11:0] RST_WINDOW_WIDTH    = 12'd500;
    localparam logic [11:0] RST_WINDOW_HEIGHT   = 12'd500;
    localparam logic [11:0] RST_SPRITE_WIDTH    = 12'd50;
    localparam logic [11:0] RST_SPRITE_HEIGHT   = 12'd50;
    localparam logic [7:0]  RST_GRAVITY_STEP    = 8'd5;
    localparam logic [7:0]  RST_WALL_LOSS       = 8'd5;
    localparam logic [7:0]  RST_FRICTION_PERIOD = 8'd2;
    localparam logic signed [W-1:0] RST_POS_X   = W'(225);
    localparam logic signed [W-1:0] RST_POS_Y   = W'(450);

    typedef struct packed {
        logic [11:0] window_width;
        logic [11:0] window_height;
        logic [11:0] sprite_width;
        logic [11:0] sprite_height;
        logic [7:0]  gravity_step;
        logic [7:0]  wall_loss;
        logic [7:0]  friction_period;
    } t_cfg;

    typedef struct packed {
        logic signed [CB-1:0] pos_x;
        logic signed [CB-1:0] pos_y;
        logic signed [CB-1:0] vel_x;
        logic signed [CB-1:0] vel_y;
        logic signed [CB-1:0] grab_x;
        logic signed [CB-1:0] grab_y;
        logic signed [CB-1:0] prev_x;
        logic signed [CB-1:0] prev_y;
        logic [7:0]           frame_count;
        logic                 held;
    } t_state;

    function automatic logic signed [CB-1:0] sat(input logic signed [W-1:0] v);
        logic signed [W-1:0] hi;
        logic signed [W-1:0] lo;
        hi = W'(2 ** (CB - 1) - 1);
        lo = -hi - W'(1);
        if (v > hi) begin
            return hi[CB-1:0];
        end else if (v < lo) begin
            return lo[CB-1:0];
        end
        return v[CB-1:0];
    endfunction

    function automatic logic signed [W-1:0] sx(input logic signed [CB-1:0] v);
        return W'(v);
    endfunction

    function automatic logic signed [W-1:0] zx12(input logic [11:0] v);
        return signed'({{(W-12){1'b0}}, v});
    endfunction

    function automatic logic signed [W-1:0] zx8(input logic [7:0] v);
        return signed'({{(W-8){1'b0}}, v});
    endfunction

    function automatic logic signed [FIELD_BITS-1:0] to_field(input logic signed [CB-1:0] v);
        logic signed [W-1:0] t;
        t = W'(v);
        return t[FIELD_BITS-1:0];
    endfunction

endpackage

// ===== design/dbs_core.sv =====
module dbs_core import dbs_pkg::*; (
    input  t_state                        i_st,
    input  t_cfg                          i_cfg,
    input  logic [1:0]                    i_operation,
    input  logic signed [FIELD_BITS-1:0]  i_pointer_x,
    input  logic signed [FIELD_BITS-1:0]  i_pointer_y,
    output t_state                        o_st
);

    logic signed [W-1:0] px, py, psx, psy, sw, sh, max_x, max_y, g, l;
    logic signed [W-1:0] nx, ny, vx, vx1, vx2, vx_f, vy;
    logic signed [CB-1:0] vy_n;
    logic                 hit, fric, wall;

    always_comb begin
        px    = W'(i_pointer_x);
        py    = W'(i_pointer_y);
        psx   = sx(i_st.pos_x);
        psy   = sx(i_st.pos_y);
        sw    = zx12(i_cfg.sprite_width);
        sh    = zx12(i_cfg.sprite_height);
        max_x = zx12(i_cfg.window_width) - sw;
        max_y = zx12(i_cfg.window_height) - sh;
        g     = zx8(i_cfg.gravity_step);
        l     = zx8(i_cfg.wall_loss);

        hit = (px >= psx) && (px <= psx + sw) && (py >= psy) && (py <= psy + sh);

        nx = px - sx(i_st.grab_x);
        ny = py - sx(i_st.grab_y);
        if (nx < 0) begin
            nx = '0;
        end else if (nx > max_x) begin
            nx = max_x;
        end
        if (ny > max_y) begin
            ny = max_y;
        end

        // horizontal: friction toward zero, then lossy wall reflection
        vx   = sx(i_st.vel_x);
        fric = (i_st.frame_count == i_cfg.friction_period);
        vx1  = vx;
        if (vx != 0 && fric) begin
            vx1 = (vx > 0) ? vx - W'(1) : vx + W'(1);
        end
        wall = (vx != 0) && ((vx1 + psx < 0) || (vx1 + psx > max_x));
        vx2  = sx(sat((vx1 > 0) ? vx1 - l : vx1 + l));
        vx_f = wall ? sx(sat(-vx2)) : vx1;

        vy   = sx(i_st.vel_y);
        vy_n = sat(vy + g);

        o_st = i_st;
        case (i_operation)
            OP_PRESS: begin
                if (hit) begin
                    o_st.held   = 1'b1;
                    o_st.grab_x = sat(px - psx);
                    o_st.grab_y = sat(py - psy);
                    o_st.prev_x = sat(px);
                    o_st.prev_y = sat(py);
                end
            end
            OP_RELEASE: begin
                o_st.held = 1'b0;
            end
            OP_MOTION: begin
                if (i_st.held) begin
                    o_st.vel_x  = sat(px - sx(i_st.prev_x));
                    o_st.vel_y  = sat(py - sx(i_st.prev_y));
                    o_st.prev_x = sat(px);
                    o_st.prev_y = sat(py);
                    o_st.pos_x  = sat(nx);
                    o_st.pos_y  = sat(ny);
                end
            end
            default: begin
                if (!i_st.held) begin
                    o_st.vel_x = sat(vx_f);
                    if (psy + vy + g < max_y) begin
                        o_st.vel_y = vy_n;
                        o_st.pos_y = sat(psy + sx(vy_n));
                    end else begin
                        o_st.vel_y = sat(-vy);
                        o_st.pos_y = sat(max_y);
                    end
                    o_st.pos_x = sat(psx + vx_f);
                end
                o_st.frame_count = fric ? 8'd0 : i_st.frame_count + 8'd1;
            end
        endcase
    end

endmodule

// ===== design/draggable_bouncing_sprite_unit.sv =====
// Draggable bouncing sprite unit.
// Input channel: i_in_valid / o_in_stall with i_operation (frame tick, left
// press, left release, pointer motion) and i_pointer_x / i_pointer_y.
// Output channel: o_out_valid / i_out_stall with o_sprite_x, o_sprite_y and
// o_dragging; each input transfer yields exactly one output transfer.
// The sprite state and the output register both load at the edge that
// accepts the item. Throughput is one item per cycle while the receiver
// does not stall, set by the single output register; the physics step is
// one pass of adds, compares and clamps on the state registers.
// When the receiver stalls with a result pending, o_in_stall rises in the
// same cycle and the result holds until taken; an item arriving on the
// cycle the result is taken is accepted.
// Configuration is an APB-style port, registers at byte offsets 4*i; write
// only while the unit is idle. pready is tied high.
// Reset (synchronous, active low) restores the register defaults, puts the
// sprite at (225, 450) at rest, not dragging, and empties the output.
module draggable_bouncing_sprite_unit import dbs_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [4:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_operation,
    input  logic signed [FIELD_BITS-1:0] i_pointer_x,
    input  logic signed [FIELD_BITS-1:0] i_pointer_y,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [FIELD_BITS-1:0] o_sprite_x,
    output logic signed [FIELD_BITS-1:0] o_sprite_y,
    output logic                         o_dragging
);

    t_cfg   r_cfg;
    t_state r_st, n_st;
    logic   r_out_valid;
    logic signed [FIELD_BITS-1:0] r_out_x, r_out_y;
    logic   r_out_drag;
    logic   in_xfer, cfg_wr;
    logic [2:0] reg_idx;

    assign pready     = 1'b1;
    assign cfg_wr     = psel & penable & pwrite;
    assign reg_idx    = paddr[4:2];
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_xfer    = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_width    <= RST_WINDOW_WIDTH;
            r_cfg.window_height   <= RST_WINDOW_HEIGHT;
            r_cfg.sprite_width    <= RST_SPRITE_WIDTH;
            r_cfg.sprite_height   <= RST_SPRITE_HEIGHT;
            r_cfg.gravity_step    <= RST_GRAVITY_STEP;
            r_cfg.wall_loss       <= RST_WALL_LOSS;
            r_cfg.friction_period <= RST_FRICTION_PERIOD;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_WINDOW_WIDTH:    r_cfg.window_width    <= pwdata[11:0];
                REG_WINDOW_HEIGHT:   r_cfg.window_height   <= pwdata[11:0];
                REG_SPRITE_WIDTH:    r_cfg.sprite_width    <= pwdata[11:0];
                REG_SPRITE_HEIGHT:   r_cfg.sprite_height   <= pwdata[11:0];
                REG_GRAVITY_STEP:    r_cfg.gravity_step    <= pwdata[7:0];
                REG_WALL_LOSS:       r_cfg.wall_loss       <= pwdata[7:0];
                REG_FRICTION_PERIOD: r_cfg.friction_period <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WINDOW_WIDTH:    prdata = {20'd0, r_cfg.window_width};
            REG_WINDOW_HEIGHT:   prdata = {20'd0, r_cfg.window_height};
            REG_SPRITE_WIDTH:    prdata = {20'd0, r_cfg.sprite_width};
            REG_SPRITE_HEIGHT:   prdata = {20'd0, r_cfg.sprite_height};
            REG_GRAVITY_STEP:    prdata = {24'd0, r_cfg.gravity_step};
            REG_WALL_LOSS:       prdata = {24'd0, r_cfg.wall_loss};
            REG_FRICTION_PERIOD: prdata = {24'd0, r_cfg.friction_period};
            default:             prdata = 32'd0;
        endcase
    end

    dbs_core u_core (
        .i_st        (r_st),
        .i_cfg       (r_cfg),
        .i_operation (i_operation),
        .i_pointer_x (i_pointer_x),
        .i_pointer_y (i_pointer_y),
        .o_st        (n_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.pos_x       <= RST_POS_X[CB-1:0];
            r_st.pos_y       <= RST_POS_Y[CB-1:0];
            r_st.vel_x       <= '0;
            r_st.vel_y       <= '0;
            r_st.grab_x      <= '0;
            r_st.grab_y      <= '0;
            r_st.prev_x      <= '0;
            r_st.prev_y      <= '0;
            r_st.frame_count <= '0;
            r_st.held        <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_st        <= n_st;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_x    <= to_field(n_st.pos_x);
            r_out_y    <= to_field(n_st.pos_y);
            r_out_drag <= n_st.held;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sprite_x  = r_out_x;
    assign o_sprite_y  = r_out_y;
    assign o_dragging  = r_out_drag;

    a_xfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_out_valid)
        else $error("accepted item produced no result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("pending result could be overwritten");

    a_drag_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_dragging == r_st.held))
        else $error("drag flag disagrees with state");

    a_held_frame_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_operation == OP_FRAME && r_st.held)
        |=> (r_st.pos_x == $past(r_st.pos_x) && r_st.pos_y == $past(r_st.pos_y)))
        else $error("held sprite moved on frame tick");

endmodule

// ===== tb/sv/tb_draggable_bouncing_sprite_unit.sv =====
`timescale 1ns / 1ps

module tb_draggable_bouncing_sprite_unit;
    import dbs_pkg::*;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] x;
        logic signed [FIELD_BITS-1:0] y;
        logic                         drag;
    } t_sprite_result;

    class t_sprite_scoreboard;
        t_cfg                 cfg;
        logic signed [CB-1:0] pos_x, pos_y, vel_x, vel_y;
        logic signed [CB-1:0] grab_x, grab_y, prev_x, prev_y;
        logic [7:0]           frame_cnt;
        logic                 held;
        t_sprite_result       sprite_q[$];
        int                   errors;

        function new();
            cfg.window_width    = RST_WINDOW_WIDTH;
            cfg.window_height   = RST_WINDOW_HEIGHT;
            cfg.sprite_width    = RST_SPRITE_WIDTH;
            cfg.sprite_height   = RST_SPRITE_HEIGHT;
            cfg.gravity_step    = RST_GRAVITY_STEP;
            cfg.wall_loss       = RST_WALL_LOSS;
            cfg.friction_period = RST_FRICTION_PERIOD;
            pos_x = RST_POS_X[CB-1:0];
            pos_y = RST_POS_Y[CB-1:0];
            vel_x = '0;
            vel_y = '0;
            grab_x = '0;
            grab_y = '0;
            prev_x = '0;
            prev_y = '0;
            frame_cnt = '0;
            held = 1'b0;
            errors = 0;
        endfunction

        function logic signed [CB-1:0] clip(longint v);
            longint lim;
            lim = longint'(1) << (CB - 1);
            if (v > lim - 1) begin
                v = lim - 1;
            end else if (v < -lim) begin
                v = -lim;
            end
            return CB'(v);
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_WINDOW_WIDTH:    cfg.window_width    = v[11:0];
                REG_WINDOW_HEIGHT:   cfg.window_height   = v[11:0];
                REG_SPRITE_WIDTH:    cfg.sprite_width    = v[11:0];
                REG_SPRITE_HEIGHT:   cfg.sprite_height   = v[11:0];
                REG_GRAVITY_STEP:    cfg.gravity_step    = v[7:0];
                REG_WALL_LOSS:       cfg.wall_loss       = v[7:0];
                REG_FRICTION_PERIOD: cfg.friction_period = v[7:0];
                default: ;
            endcase
        endfunction

        function void note(logic [1:0] op, logic signed [FIELD_BITS-1:0] ptr_x,
                           logic signed [FIELD_BITS-1:0] ptr_y);
            longint px, py, sw, sh, mx, my, cx, cy, vx, vy, g, l, nx, ny;
            t_sprite_result r;
            px = ptr_x;
            py = ptr_y;
            sw = longint'(cfg.sprite_width);
            sh = longint'(cfg.sprite_height);
            mx = longint'(cfg.window_width) - sw;
            my = longint'(cfg.window_height) - sh;
            cx = pos_x;
            cy = pos_y;
            vx = vel_x;
            vy = vel_y;
            case (op)
                OP_PRESS: begin
                    if (px >= cx && px <= cx + sw && py >= cy && py <= cy + sh) begin
                        held = 1'b1;
                        grab_x = clip(px - cx);
                        grab_y = clip(py - cy);
                        prev_x = clip(px);
                        prev_y = clip(py);
                    end
                end
                OP_RELEASE: held = 1'b0;
                OP_MOTION: begin
                    if (held) begin
                        vel_x = clip(px - prev_x);
                        vel_y = clip(py - prev_y);
                        prev_x = clip(px);
                        prev_y = clip(py);
                        nx = px - grab_x;
                        ny = py - grab_y;
                        if (nx < 0) begin
                            nx = 0;
                        end else if (nx > mx) begin
                            nx = mx;
                        end
                        if (ny > my) begin
                            ny = my;
                        end
                        pos_x = clip(nx);
                        pos_y = clip(ny);
                    end
                end
                default: begin
                    if (!held) begin
                        g = longint'(cfg.gravity_step);
                        l = longint'(cfg.wall_loss);
                        if (vx != 0) begin
                            if (frame_cnt == cfg.friction_period) begin
                                vx = clip(vx + ((vx > 0) ? -1 : 1));
                            end
                            // wall hit: lose speed, then reverse
                            if (vx + cx < 0 || vx + cx > mx) begin
                                vx = clip(vx + ((vx > 0) ? -l : l));
                                vx = clip(-vx);
                            end
                        end
                        if (cy + vy + g < my) begin
                            vy = clip(vy + g);
                            cy = clip(cy + vy);
                        end else begin
                            cy = clip(my);
                            vy = clip(-vy);
                        end
                        vel_x = CB'(vx);
                        vel_y = CB'(vy);
                        pos_y = CB'(cy);
                        pos_x = clip(cx + vx);
                    end
                    if (frame_cnt == cfg.friction_period) begin
                        frame_cnt = '0;
                    end else begin
                        frame_cnt = frame_cnt + 8'd1;
                    end
                end
            endcase
            r.x = pos_x;
            r.y = pos_y;
            r.drag = held;
            sprite_q.push_back(r);
        endfunction

        function void check(logic signed [FIELD_BITS-1:0] x,
                            logic signed [FIELD_BITS-1:0] y, logic drag);
            t_sprite_result e;
            if (sprite_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected transfer: x=%0d y=%0d drag=%0b", x, y, drag);
                end
                return;
            end
            e = sprite_q.pop_front();
            if (e.x !== x || e.y !== y || e.drag !== drag) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp x=%0d y=%0d drag=%0b, got x=%0d y=%0d drag=%0b",
                             e.x, e.y, e.drag, x, y, drag);
                end
            end
        endfunction

        function int pending();
            return sprite_q.size();
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [4:0]                   paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic [1:0]                   i_operation = OP_FRAME;
    logic signed [FIELD_BITS-1:0] i_pointer_x = '0;
    logic signed [FIELD_BITS-1:0] i_pointer_y = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic signed [FIELD_BITS-1:0] o_sprite_x;
    logic signed [FIELD_BITS-1:0] o_sprite_y;
    logic                         o_dragging;

    t_sprite_scoreboard sb = new();
    int send_pct = 11;
    int recv_pct = 60;
    int sent_count = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;

    draggable_bouncing_sprite_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_pointer_x (i_pointer_x),
        .i_pointer_y (i_pointer_y),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sprite_x  (o_sprite_x),
        .o_sprite_y  (o_sprite_y),
        .o_dragging  (o_dragging)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    // result side: check transfers, drive stall
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sb.check(o_sprite_x, o_sprite_y, o_dragging);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 300;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_pct);
            end
        end
    end

    function automatic logic signed [FIELD_BITS-1:0] rand_coord();
        return FIELD_BITS'($urandom());
    endfunction

    function automatic longint jitter();
        int r;
        r = $urandom_range(99);
        if (r < 80) begin
            return longint'($urandom_range(60)) - 30;
        end else if (r < 92) begin
            return longint'($urandom_range(4000)) - 2000;
        end
        return longint'($urandom_range(131070)) - 65535;
    endfunction

    task automatic send_item(logic [1:0] op, logic signed [FIELD_BITS-1:0] px,
                             logic signed [FIELD_BITS-1:0] py);
        if (sent_count < 570) begin
            send_pct = 11;
            recv_pct = 60;
        end else if (sent_count < 1130) begin
            send_pct = 60;
            recv_pct = 11;
        end else begin
            send_pct = 0;
            recv_pct = 0;
        end
        while ($urandom_range(99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_pointer_x <= px;
        i_pointer_y <= py;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.note(op, px, py);
        sent_count++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, v);
        @(posedge i_clk);
    endtask

    task automatic load_config(t_cfg c);
        apb_write(REG_WINDOW_WIDTH, 32'(c.window_width));
        apb_write(REG_WINDOW_HEIGHT, 32'(c.window_height));
        apb_write(REG_SPRITE_WIDTH, 32'(c.sprite_width));
        apb_write(REG_SPRITE_HEIGHT, 32'(c.sprite_height));
        apb_write(REG_GRAVITY_STEP, 32'(c.gravity_step));
        apb_write(REG_WALL_LOSS, 32'(c.wall_loss));
        apb_write(REG_FRICTION_PERIOD, 32'(c.friction_period));
    endtask

    task automatic frame_burst(int n);
        repeat (n) send_item(OP_FRAME, rand_coord(), rand_coord());
    endtask

    task automatic drag_burst();
        longint bx, by;
        int n;
        bx = longint'(sb.pos_x) + $urandom_range(sb.cfg.sprite_width);
        by = longint'(sb.pos_y) + $urandom_range(sb.cfg.sprite_height);
        send_item(OP_PRESS, FIELD_BITS'(bx), FIELD_BITS'(by));
        n = $urandom_range(1, 8);
        repeat (n) begin
            if (sb.held) begin
                bx = sb.prev_x;
                by = sb.prev_y;
            end
            bx = bx + jitter();
            by = by + jitter();
            send_item(OP_MOTION, FIELD_BITS'(bx), FIELD_BITS'(by));
        end
        if ($urandom_range(9) != 0) begin
            send_item(OP_RELEASE, rand_coord(), rand_coord());
        end
        frame_burst($urandom_range(20));
    endtask

    task automatic random_scenario();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            drag_burst();
        end else if (r < 85) begin
            frame_burst($urandom_range(1, 15));
        end else begin
            send_item(2'($urandom_range(3)), rand_coord(), rand_coord());
        end
    endtask

    task automatic directed_items();
        send_item(OP_FRAME, '0, '0);
        send_item(OP_FRAME, -16'sd1, -16'sd1);
        send_item(OP_PRESS, -16'sd32768, -16'sd32768);
        send_item(OP_RELEASE, 16'sd32767, -16'sd32768);
        send_item(OP_MOTION, 16'sd32767, 16'sd32767);
        send_item(OP_PRESS, sb.pos_x, sb.pos_y);
        send_item(OP_MOTION, 16'sd32767, 16'sd32767);
        send_item(OP_MOTION, -16'sd32768, -16'sd32768);
        send_item(OP_PRESS, sb.pos_x + FIELD_BITS'(sb.cfg.sprite_width),
                  sb.pos_y + FIELD_BITS'(sb.cfg.sprite_height));
        send_item(OP_MOTION, sb.prev_x + 16'sd10, sb.prev_y + 16'sd5);
        send_item(OP_FRAME, '0, '0);
        send_item(OP_RELEASE, '0, '0);
        frame_burst(8);
        send_item(OP_PRESS, sb.pos_x + FIELD_BITS'(sb.cfg.sprite_width) + 16'sd1, sb.pos_y);
        send_item(OP_PRESS, sb.pos_x, sb.pos_y - 16'sd1);
        send_item(OP_PRESS, sb.pos_x + 16'sd20, sb.pos_y + 16'sd20);
        send_item(OP_MOTION, sb.prev_x + 16'sd200, sb.prev_y - 16'sd90);
        send_item(OP_RELEASE, '0, '0);
    endtask

    initial begin
        t_cfg c;
        int goal;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        c = sb.cfg;
        load_config(c);
        directed_items();
        for (int p = 0; p < 6; p++) begin
            drain_results();
            case (p)
                0: c = sb.cfg;
                1: c = '{12'd4095, 12'd4095, 12'd1, 12'd1, 8'd255, 8'd255, 8'd0};
                2: c = '{12'd1, 12'd1, 12'd4095, 12'd4095, 8'd0, 8'd0, 8'd255};
                3: begin
                    c.window_width    = 12'($urandom_range(200, 800));
                    c.window_height   = 12'($urandom_range(200, 800));
                    c.sprite_width    = 12'($urandom_range(8, 100));
                    c.sprite_height   = 12'($urandom_range(8, 100));
                    c.gravity_step    = 8'($urandom_range(12));
                    c.wall_loss       = 8'($urandom_range(12));
                    c.friction_period = 8'($urandom_range(6));
                end
                4: begin
                    c.window_width    = 12'($urandom_range(1, 4095));
                    c.window_height   = 12'($urandom_range(1, 4095));
                    c.sprite_width    = 12'($urandom_range(1, 4095));
                    c.sprite_height   = 12'($urandom_range(1, 4095));
                    c.gravity_step    = 8'($urandom_range(255));
                    c.wall_loss       = 8'($urandom_range(255));
                    c.friction_period = 8'($urandom_range(255));
                end
                default: c = '{12'd640, 12'd480, 12'd32, 12'd32, 8'd1, 8'd2, 8'd3};
            endcase
            load_config(c);
            if (p == 3) begin
                hold_req = 1'b1;
            end
            goal = 25 + (p + 1) * 275;
            while (sent_count < goal) begin
                random_scenario();
                if (p == 4 && sent_count > goal - 140 && sent_count < goal - 120) begin
                    drain_results();
                end
            end
        end
        drain_results();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
